>>> sv/cpec_pkg.sv
// Shared types, widths and saturation helpers for the circle pair collision block.
// Used by the cell modules and by the top level; no dependencies.
`timescale 1ns / 1ps

package cpec_pkg;

  localparam int POS_W = 20;
  localparam int VEL_W = 16;
  localparam int RAD_W = 12;

  // isqrt of S*2^16 with S below 2^26 while overlapping: 21 root bits
  localparam int SQ_N   = 21;
  localparam int SQ_IN_W  = 2 * SQ_N;
  localparam int SQ_REM_W = SQ_N + 2;

  // dividers: 18 quotient bits, divisor up to 26 bits
  localparam int DV_N    = 18;
  localparam int DEN_W   = 26;
  localparam int DREM_W  = DEN_W + DV_N;
  localparam int LANES   = 4;
  localparam int LANE_PX = 0;
  localparam int LANE_PY = 1;
  localparam int LANE_IX = 2;
  localparam int LANE_IY = 3;

  typedef struct packed {
    logic signed [POS_W-1:0] p1x;
    logic signed [POS_W-1:0] p1y;
    logic signed [VEL_W-1:0] v1x;
    logic signed [VEL_W-1:0] v1y;
    logic signed [POS_W-1:0] p2x;
    logic signed [POS_W-1:0] p2y;
    logic signed [VEL_W-1:0] v2x;
    logic signed [VEL_W-1:0] v2y;
  } pair_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_N-1:0]     root;
    logic [SQ_IN_W-1:0]  rad;
  } sqrt_t;

  typedef struct packed {
    pair_t              pair;
    logic [RAD_W:0]     rsum;
    logic signed [13:0] dx;
    logic signed [13:0] dy;
    logic signed [31:0] t;
    logic [DEN_W-1:0]   s;
    logic               ov;
    logic               tle;
  } sqrt_side_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [DEN_W-1:0]  den;
    logic [DV_N-1:0]   q;
  } div_lane_t;

  typedef struct packed {
    pair_t            pair;
    logic             ov;
    logic             tle;
    logic [LANES-1:0] neg;
  } div_side_t;

  typedef struct packed {
    pair_t pair;
    logic  ov;
    logic  hit;
  } res_t;

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
    logic [POS_W-1:0] r;
    if (v[POS_W+1:POS_W-1] == '0 || v[POS_W+1:POS_W-1] == '1) begin
      r = v[POS_W-1:0];
    end else begin
      r = {v[POS_W+1], {(POS_W-1){~v[POS_W+1]}}};
    end
    return r;
  endfunction

  function automatic logic [VEL_W-1:0] sat_vel(input logic signed [VEL_W+3:0] v);
    logic [VEL_W-1:0] r;
    if (v[VEL_W+3:VEL_W-1] == '0 || v[VEL_W+3:VEL_W-1] == '1) begin
      r = v[VEL_W-1:0];
    end else begin
      r = {v[VEL_W+3], {(VEL_W-1){~v[VEL_W+3]}}};
    end
    return r;
  endfunction

endpackage

>>> sv/cpec_sqrt_cell.sv
// One digit cell of the pipelined square root: settles one root bit per cell.
// Depends on cpec_pkg.
`timescale 1ns / 1ps

module cpec_sqrt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cpec_pkg::sqrt_t     in_data_i,
  input  cpec_pkg::sqrt_side_t in_side_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cpec_pkg::sqrt_t     out_data_o,
  output cpec_pkg::sqrt_side_t out_side_o
);

  logic                 valid_q;
  logic                 en;
  cpec_pkg::sqrt_t      data_d, data_q;
  cpec_pkg::sqrt_side_t side_q;
  logic [cpec_pkg::SQ_REM_W+1:0] rem2, trial, diff;
  logic                 ge;

  assign en = !valid_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    rem2  = {in_data_i.rem, in_data_i.rad[cpec_pkg::SQ_IN_W-1 -: 2]};
    trial = {2'b00, in_data_i.root, 2'b01};
    ge    = rem2 >= trial;
    diff  = rem2 - trial;
    data_d.rem  = ge ? diff[cpec_pkg::SQ_REM_W-1:0] : rem2[cpec_pkg::SQ_REM_W-1:0];
    data_d.root = {in_data_i.root[cpec_pkg::SQ_N-2:0], ge};
    data_d.rad  = {in_data_i.rad[cpec_pkg::SQ_IN_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      data_q <= data_d;
      side_q <= in_side_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_side_o  = side_q;

endmodule

>>> sv/cpec_div_cell.sv
// One step of four parallel restoring dividers: one quotient bit per lane.
// Depends on cpec_pkg.
`timescale 1ns / 1ps

module cpec_div_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cpec_pkg::div_lane_t   in_data_i [cpec_pkg::LANES],
  input  cpec_pkg::div_side_t   in_side_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cpec_pkg::div_lane_t   out_data_o [cpec_pkg::LANES],
  output cpec_pkg::div_side_t   out_side_o
);

  logic                valid_q;
  logic                en;
  cpec_pkg::div_lane_t data_d [cpec_pkg::LANES];
  cpec_pkg::div_lane_t data_q [cpec_pkg::LANES];
  cpec_pkg::div_side_t side_q;

  assign en = !valid_q || out_ready_i;
  assign in_ready_o = en;

  // divisor is held aligned to the top quotient bit; the remainder shifts up
  always_comb begin
    for (int l = 0; l < cpec_pkg::LANES; l++) begin
      logic [cpec_pkg::DREM_W-1:0] dsh, r1;
      logic ge;
      dsh = {1'b0, in_data_i[l].den, {(cpec_pkg::DV_N-1){1'b0}}};
      ge  = in_data_i[l].rem >= dsh;
      r1  = ge ? in_data_i[l].rem - dsh : in_data_i[l].rem;
      data_d[l].rem = {r1[cpec_pkg::DREM_W-2:0], 1'b0};
      data_d[l].den = in_data_i[l].den;
      data_d[l].q   = {in_data_i[l].q[cpec_pkg::DV_N-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      data_q <= data_d;
      side_q <= in_side_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_side_o  = side_q;

endmodule

>>> sv/circle_pair_elastic_collision.sv
// Top level: equal-mass elastic collision of a circle pair, fully pipelined.
// Depends on cpec_pkg, cpec_sqrt_cell and cpec_div_cell.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------------
//   in      | in_valid_i / in_ready_o  | first_*, second_* position/vel/radius
//   out     | out_valid_o / out_ready_i| new_* positions/velocities, flags
//
// One request per cycle sustained while out_ready_i stays high; the pipeline is three setup stages,
// 21 square-root cells, two stages for the scaled numerators, 18 divider
// cells and the output register.
// Reset clears only the stage valid flags.
// Each stage holds while its successor is full and stalled; ready ripples
// back through the row, so empty stages keep filling under an output stall.
`timescale 1ns / 1ps

module circle_pair_elastic_collision (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [19:0] first_pos_x_i,
  input  logic signed [19:0] first_pos_y_i,
  input  logic signed [15:0] first_vel_x_i,
  input  logic signed [15:0] first_vel_y_i,
  input  logic        [11:0] first_radius_i,
  input  logic signed [19:0] second_pos_x_i,
  input  logic signed [19:0] second_pos_y_i,
  input  logic signed [15:0] second_vel_x_i,
  input  logic signed [15:0] second_vel_y_i,
  input  logic        [11:0] second_radius_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [19:0] new_first_pos_x_o,
  output logic signed [19:0] new_first_pos_y_o,
  output logic signed [15:0] new_first_vel_x_o,
  output logic signed [15:0] new_first_vel_y_o,
  output logic signed [19:0] new_second_pos_x_o,
  output logic signed [19:0] new_second_pos_y_o,
  output logic signed [15:0] new_second_vel_x_o,
  output logic signed [15:0] new_second_vel_y_o,
  output logic        overlapped_o,
  output logic        hit_o
);

  localparam int SQ_N = cpec_pkg::SQ_N;
  localparam int DV_N = cpec_pkg::DV_N;

  // ---------------- stage 1: differences
  logic               v1_q, en1;
  cpec_pkg::pair_t    pr1_q;
  logic signed [20:0] dx1_q, dy1_q;
  logic signed [16:0] dvx1_q, dvy1_q;
  logic [12:0]        r1_q;

  // ---------------- stage 2: products
  logic               v2_q, en2;
  cpec_pkg::pair_t    pr2_q;
  logic signed [41:0] sxx2_q, syy2_q;
  logic signed [37:0] tx2_q, ty2_q;
  logic [25:0]        rr2_q;
  logic signed [13:0] dx2_q, dy2_q;
  logic [12:0]        r2_q;

  // ---------------- stage 3: sums and overlap test
  logic                 v3_q, en3;
  cpec_pkg::sqrt_side_t side3_d, side3_q;
  logic [40:0]          s3;
  logic signed [38:0]   t3;

  // ---------------- sqrt row
  logic [SQ_N:0]        sq_valid, sq_ready;
  cpec_pkg::sqrt_t      sq_data [SQ_N+1];
  cpec_pkg::sqrt_side_t sq_side [SQ_N+1];

  // ---------------- stage E: numerator products
  logic                 ve_q, ene;
  cpec_pkg::div_side_t  sidee_q;
  logic [20:0]          de_q;
  logic [25:0]          se_q;
  logic [33:0]          pxm_q, pym_q;
  logic [44:0]          ixm_q, iym_q;
  logic [20:0]          oe;
  logic [12:0]          adx, ady;
  logic [13:0]          adx_w, ady_w;
  logic [31:0]          at;

  // ---------------- stage F: rounding offsets, divider load
  logic                 vf_q, enf;
  cpec_pkg::div_side_t  sidef_q;
  cpec_pkg::div_lane_t  lanef_q [cpec_pkg::LANES];

  // ---------------- divider row
  logic [DV_N:0]        dv_valid, dv_ready;
  cpec_pkg::div_lane_t  dv_data [DV_N+1][cpec_pkg::LANES];
  cpec_pkg::div_side_t  dv_side [DV_N+1];

  // ---------------- output register
  logic                 vo_q, eno;
  cpec_pkg::res_t       res_d, res_q;
  logic signed [18:0]   qs [cpec_pkg::LANES];

  assign en1 = !v1_q || en2;
  assign en2 = !v2_q || en3;
  assign en3 = !v3_q || sq_ready[0];
  assign ene = !ve_q || enf;
  assign enf = !vf_q || dv_ready[0];
  assign eno = !vo_q || out_ready_i;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (ene) ve_q <= sq_valid[SQ_N];
      if (enf) vf_q <= ve_q;
      if (eno) vo_q <= dv_valid[DV_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      pr1_q.p1x <= first_pos_x_i;
      pr1_q.p1y <= first_pos_y_i;
      pr1_q.v1x <= first_vel_x_i;
      pr1_q.v1y <= first_vel_y_i;
      pr1_q.p2x <= second_pos_x_i;
      pr1_q.p2y <= second_pos_y_i;
      pr1_q.v2x <= second_vel_x_i;
      pr1_q.v2y <= second_vel_y_i;
      dx1_q  <= 21'(second_pos_x_i) - 21'(first_pos_x_i);
      dy1_q  <= 21'(second_pos_y_i) - 21'(first_pos_y_i);
      dvx1_q <= 17'(second_vel_x_i) - 17'(first_vel_x_i);
      dvy1_q <= 17'(second_vel_y_i) - 17'(first_vel_y_i);
      r1_q   <= 13'(first_radius_i) + 13'(second_radius_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      pr2_q  <= pr1_q;
      sxx2_q <= dx1_q * dx1_q;
      syy2_q <= dy1_q * dy1_q;
      tx2_q  <= dvx1_q * dx1_q;
      ty2_q  <= dvy1_q * dy1_q;
      rr2_q  <= r1_q * r1_q;
      dx2_q  <= dx1_q[13:0];
      dy2_q  <= dy1_q[13:0];
      r2_q   <= r1_q;
    end
  end

  // squares are non-negative, so the sum is taken unsigned
  always_comb begin
    logic [41:0] ssum;
    ssum = sxx2_q + syy2_q;
    s3   = ssum[40:0];
    t3   = 39'(tx2_q) + 39'(ty2_q);
    side3_d.pair = pr2_q;
    side3_d.rsum = r2_q;
    side3_d.dx   = dx2_q;
    side3_d.dy   = dy2_q;
    side3_d.t    = t3[31:0];
    side3_d.ov   = (s3 != '0) && (s3 < 41'(rr2_q));
    side3_d.s    = side3_d.ov ? s3[25:0] : '0;
    side3_d.tle  = t3[38] || (t3 == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      side3_q <= side3_d;
    end
  end

  assign sq_valid[0]     = v3_q;
  assign sq_data[0].rem  = '0;
  assign sq_data[0].root = '0;
  assign sq_data[0].rad  = {side3_q.s, 16'b0};
  assign sq_side[0]      = side3_q;

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    cpec_sqrt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (sq_valid[k]),
      .in_ready_o  (sq_ready[k]),
      .in_data_i   (sq_data[k]),
      .in_side_i   (sq_side[k]),
      .out_valid_o (sq_valid[k+1]),
      .out_ready_i (sq_ready[k+1]),
      .out_data_o  (sq_data[k+1]),
      .out_side_o  (sq_side[k+1])
    );
  end
  assign sq_ready[SQ_N] = ene;

  // overlap, magnitudes of the normal and of T
  always_comb begin
    oe    = {sq_side[SQ_N].rsum, 8'b0} - sq_data[SQ_N].root;
    adx_w = sq_side[SQ_N].dx[13] ? 14'(-sq_side[SQ_N].dx) : sq_side[SQ_N].dx;
    ady_w = sq_side[SQ_N].dy[13] ? 14'(-sq_side[SQ_N].dy) : sq_side[SQ_N].dy;
    adx   = adx_w[12:0];
    ady   = ady_w[12:0];
    at    = sq_side[SQ_N].t[31] ? (~sq_side[SQ_N].t + 32'd1) : sq_side[SQ_N].t;
  end

  always_ff @(posedge clk_i) begin
    if (ene && sq_valid[SQ_N]) begin
      sidee_q.pair <= sq_side[SQ_N].pair;
      sidee_q.ov   <= sq_side[SQ_N].ov;
      sidee_q.tle  <= sq_side[SQ_N].tle;
      sidee_q.neg[cpec_pkg::LANE_PX] <= sq_side[SQ_N].dx[13];
      sidee_q.neg[cpec_pkg::LANE_PY] <= sq_side[SQ_N].dy[13];
      sidee_q.neg[cpec_pkg::LANE_IX] <= sq_side[SQ_N].dx[13] ^ sq_side[SQ_N].t[31];
      sidee_q.neg[cpec_pkg::LANE_IY] <= sq_side[SQ_N].dy[13] ^ sq_side[SQ_N].t[31];
      de_q  <= sq_data[SQ_N].root;
      se_q  <= sq_side[SQ_N].s;
      pxm_q <= adx * oe;
      pym_q <= ady * oe;
      ixm_q <= adx * at;
      iym_q <= ady * at;
    end
  end

  // push divides by 2D with D as half-divisor; impulse divides by S
  always_ff @(posedge clk_i) begin
    if (enf && ve_q) begin
      sidef_q <= sidee_q;
      lanef_q[cpec_pkg::LANE_PX].rem <= 44'(pxm_q) + 44'(de_q);
      lanef_q[cpec_pkg::LANE_PY].rem <= 44'(pym_q) + 44'(de_q);
      lanef_q[cpec_pkg::LANE_IX].rem <= ixm_q[43:0] + 44'(se_q[25:1]);
      lanef_q[cpec_pkg::LANE_IY].rem <= iym_q[43:0] + 44'(se_q[25:1]);
      lanef_q[cpec_pkg::LANE_PX].den <= 26'({de_q, 1'b0});
      lanef_q[cpec_pkg::LANE_PY].den <= 26'({de_q, 1'b0});
      lanef_q[cpec_pkg::LANE_IX].den <= se_q;
      lanef_q[cpec_pkg::LANE_IY].den <= se_q;
      for (int l = 0; l < cpec_pkg::LANES; l++) begin
        lanef_q[l].q <= '0;
      end
    end
  end

  assign dv_valid[0] = vf_q;
  assign dv_data[0]  = lanef_q;
  assign dv_side[0]  = sidef_q;

  for (genvar k = 0; k < DV_N; k++) begin : g_dv
    cpec_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (dv_valid[k]),
      .in_ready_o  (dv_ready[k]),
      .in_data_i   (dv_data[k]),
      .in_side_i   (dv_side[k]),
      .out_valid_o (dv_valid[k+1]),
      .out_ready_i (dv_ready[k+1]),
      .out_data_o  (dv_data[k+1]),
      .out_side_o  (dv_side[k+1])
    );
  end
  assign dv_ready[DV_N] = eno;

  always_comb begin
    cpec_pkg::pair_t p;
    logic            imp;
    p   = dv_side[DV_N].pair;
    imp = dv_side[DV_N].ov && dv_side[DV_N].tle;
    for (int l = 0; l < cpec_pkg::LANES; l++) begin
      qs[l] = dv_side[DV_N].neg[l] ? -$signed({1'b0, dv_data[DV_N][l].q})
                                   :  $signed({1'b0, dv_data[DV_N][l].q});
    end
    res_d.pair = p;
    res_d.ov   = dv_side[DV_N].ov;
    res_d.hit  = imp;
    if (dv_side[DV_N].ov) begin
      res_d.pair.p1x = cpec_pkg::sat_pos(22'(p.p1x) - 22'(qs[cpec_pkg::LANE_PX]));
      res_d.pair.p1y = cpec_pkg::sat_pos(22'(p.p1y) - 22'(qs[cpec_pkg::LANE_PY]));
      res_d.pair.p2x = cpec_pkg::sat_pos(22'(p.p2x) + 22'(qs[cpec_pkg::LANE_PX]));
      res_d.pair.p2y = cpec_pkg::sat_pos(22'(p.p2y) + 22'(qs[cpec_pkg::LANE_PY]));
    end
    if (imp) begin
      res_d.pair.v1x = cpec_pkg::sat_vel(20'(p.v1x) + 20'(qs[cpec_pkg::LANE_IX]));
      res_d.pair.v1y = cpec_pkg::sat_vel(20'(p.v1y) + 20'(qs[cpec_pkg::LANE_IY]));
      res_d.pair.v2x = cpec_pkg::sat_vel(20'(p.v2x) - 20'(qs[cpec_pkg::LANE_IX]));
      res_d.pair.v2y = cpec_pkg::sat_vel(20'(p.v2y) - 20'(qs[cpec_pkg::LANE_IY]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (eno && dv_valid[DV_N]) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = vo_q;
  assign new_first_pos_x_o  = res_q.pair.p1x;
  assign new_first_pos_y_o  = res_q.pair.p1y;
  assign new_first_vel_x_o  = res_q.pair.v1x;
  assign new_first_vel_y_o  = res_q.pair.v1y;
  assign new_second_pos_x_o = res_q.pair.p2x;
  assign new_second_pos_y_o = res_q.pair.p2y;
  assign new_second_vel_x_o = res_q.pair.v2x;
  assign new_second_vel_y_o = res_q.pair.v2y;
  assign overlapped_o       = res_q.ov;
  assign hit_o              = res_q.hit;

  // ---------------- assertions
  a_hit_needs_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!hit_o || overlapped_o))
    else $error("hit without overlap");

  a_empty_out_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked while output register empty");

  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_valid[SQ_N] && sq_side[SQ_N].ov) |-> (sq_data[SQ_N].root >= 21'd256))
    else $error("distance below one unit on an overlapping pair");

  a_push_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_valid[DV_N] && dv_side[DV_N].ov) |->
      (dv_data[DV_N][cpec_pkg::LANE_PX].q <= 18'd4097))
    else $error("push quotient out of range");

endmodule
